// ----- sv/ppf_pkg.sv -----
// ----------------------------------------------------------------------------
// ppf_pkg
// Shared types and constants of the pinned page frame pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ppf_pkg;

  localparam int NUM_FRAMES   = 16;
  localparam int FRAME_BITS   = 4;
  localparam int CNT_BITS     = 5;
  localparam int PAGE_BITS    = 32;
  localparam int MODE_BITS    = 3;
  localparam int STAT_BITS    = 2;
  localparam int DEF_PIN_BITS = 8;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CNT_BITS-1:0] LIMIT_RESET = CNT_BITS'(NUM_FRAMES);

  localparam logic [MODE_BITS-1:0] MODE_FETCH     = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_CREATE    = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_UNPIN     = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_FLUSH     = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_FLUSH_ALL = 3'd4;

  localparam logic [STAT_BITS-1:0] ST_HIT    = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_NEW    = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_ABSENT = 2'd2;
  localparam logic [STAT_BITS-1:0] ST_FULL   = 2'd3;

  typedef enum logic [2:0] {
    OP_FETCH,
    OP_CREATE,
    OP_UNPIN,
    OP_FLUSH,
    OP_FLUSH_ALL,
    OP_BAD
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [PAGE_BITS-1:0] page;
    logic                 set_dirty;
  } req_t;

  typedef struct packed {
    logic [STAT_BITS-1:0]  status;
    logic [FRAME_BITS-1:0] frame_index;
    logic                  load_request;
    logic                  writeback_valid;
    logic [PAGE_BITS-1:0]  writeback_page;
    logic [FRAME_BITS-1:0] writeback_frame;
    logic [CNT_BITS-1:0]   resident_count;
    logic                  last;
  } res_t;

endpackage
`default_nettype wire

// ----- sv/ppf_fifo.sv -----
// ----------------------------------------------------------------------------
// ppf_fifo
// Small synchronous queue with full and empty flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ppf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_q, rd_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule
`default_nettype wire

// ----- sv/ppf_front.sv -----
// ----------------------------------------------------------------------------
// ppf_front
// Accepts requests and classifies the mode code into an operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ppf_front (
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [ppf_pkg::MODE_BITS-1:0] mode_i,
  input  wire logic [ppf_pkg::PAGE_BITS-1:0] page_id_i,
  input  wire logic                          set_dirty_i,
  input  wire logic                          q_full_i,
  output logic                               q_push_o,
  output ppf_pkg::req_t                      q_req_o
);
  import ppf_pkg::*;

  op_e op;

  always_comb begin
    case (mode_i)
      MODE_FETCH:     op = OP_FETCH;
      MODE_CREATE:    op = OP_CREATE;
      MODE_UNPIN:     op = OP_UNPIN;
      MODE_FLUSH:     op = OP_FLUSH;
      MODE_FLUSH_ALL: op = OP_FLUSH_ALL;
      default:        op = OP_BAD;
    endcase
  end

  assign full     = q_full_i;
  assign q_push_o = push && !q_full_i;
  assign q_req_o  = '{op: op, page: page_id_i, set_dirty: set_dirty_i};
endmodule
`default_nettype wire

// ----- sv/ppf_back.sv -----
// ----------------------------------------------------------------------------
// ppf_back
// Frame table and the sequencer that carries out one request at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ppf_back #(
  parameter int PIN_BITS = ppf_pkg::DEF_PIN_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [ppf_pkg::CNT_BITS-1:0] limit_i,
  input  wire logic                         q_empty_i,
  input  wire ppf_pkg::req_t                q_req_i,
  output logic                              q_pop_o,
  input  wire logic                         out_full_i,
  output logic                              out_push_o,
  output ppf_pkg::res_t                     out_res_o
);
  import ppf_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_EXEC, S_ALLOC, S_OUT, S_WALK} state_e;

  localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};
  localparam logic [PIN_BITS-1:0] PIN_ONE = PIN_BITS'(1);

  state_e                state_q;
  logic                  valid_q [NUM_FRAMES];
  logic [PAGE_BITS-1:0]  page_q  [NUM_FRAMES];
  logic [PIN_BITS-1:0]   pins_q  [NUM_FRAMES];
  logic                  dirty_q [NUM_FRAMES];
  logic                  evict_q [NUM_FRAMES];
  logic [FRAME_BITS-1:0] rec_q   [NUM_FRAMES];
  logic [CNT_BITS-1:0]   occ_q, ecnt_q;
  req_t                  req_q;
  logic                  hit_q;
  logic [FRAME_BITS-1:0] hidx_q, widx_q;
  logic                  wbv_q;
  logic [PAGE_BITS-1:0]  wbp_q;
  logic [FRAME_BITS-1:0] wbf_q;
  res_t                  res_q;

  logic                  hit_c, vic_any, free_any, dirty_any, above_any, cur_dirty;
  logic [FRAME_BITS-1:0] hidx_c, vic_idx, free_idx;
  logic [CNT_BITS-1:0]   lim;
  logic [PIN_BITS-1:0]   unpin_pins;
  logic                  page_we;
  logic [FRAME_BITS-1:0] page_wa;
  logic                  walk_push;

  always_comb begin
    lim = limit_i;
    if (limit_i == '0) lim = CNT_BITS'(1);
    else if (limit_i > CNT_BITS'(NUM_FRAMES)) lim = CNT_BITS'(NUM_FRAMES);
  end

  // parallel tag compare, victim pick (oldest rank) and first free frame
  always_comb begin
    hit_c = 1'b0; hidx_c = '0;
    vic_any = 1'b0; vic_idx = '0;
    free_any = 1'b0; free_idx = '0;
    dirty_any = 1'b0; above_any = 1'b0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (!hit_c && valid_q[i] && page_q[i] == req_q.page) begin
        hit_c = 1'b1; hidx_c = FRAME_BITS'(i);
      end
      if (!vic_any && valid_q[i] && evict_q[i] &&
          CNT_BITS'(rec_q[i]) == ecnt_q - 1'b1) begin
        vic_any = 1'b1; vic_idx = FRAME_BITS'(i);
      end
      if (!free_any && !valid_q[i]) begin
        free_any = 1'b1; free_idx = FRAME_BITS'(i);
      end
      if (valid_q[i] && dirty_q[i]) begin
        dirty_any = 1'b1;
        if (FRAME_BITS'(i) > widx_q) above_any = 1'b1;
      end
    end
  end

  assign cur_dirty  = valid_q[widx_q] && dirty_q[widx_q];
  assign unpin_pins = (pins_q[hidx_q] == '0) ? '0 : pins_q[hidx_q] - 1'b1;
  assign walk_push  = (state_q == S_WALK) && cur_dirty && !out_full_i;
  assign q_pop_o    = (state_q == S_IDLE) && !q_empty_i;
  assign page_we    = (state_q == S_ALLOC) && free_any;
  assign page_wa    = free_idx;

  always_comb begin
    out_push_o = 1'b0;
    out_res_o  = res_q;
    if (state_q == S_OUT) begin
      out_push_o = !out_full_i;
    end else if (walk_push) begin
      out_push_o = 1'b1;
      out_res_o  = '{status: ST_HIT, frame_index: '0, load_request: 1'b0,
                     writeback_valid: 1'b1, writeback_page: page_q[widx_q],
                     writeback_frame: widx_q, resident_count: occ_q,
                     last: !above_any};
    end
  end

  always_ff @(posedge clk_i) begin
    if (page_we) begin
      page_q[page_wa] <= req_q.page;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        valid_q[i] <= 1'b0;
        pins_q[i]  <= '0;
        dirty_q[i] <= 1'b0;
        evict_q[i] <= 1'b0;
        rec_q[i]   <= '0;
      end
      occ_q  <= '0;
      ecnt_q <= '0;
      req_q  <= '0;
      hit_q  <= 1'b0;
      hidx_q <= '0;
      widx_q <= '0;
      wbv_q  <= 1'b0;
      wbp_q  <= '0;
      wbf_q  <= '0;
      res_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            req_q   <= q_req_i;
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          hit_q   <= hit_c;
          hidx_q  <= hidx_c;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          res_q   <= '{status: ST_ABSENT, frame_index: '0, load_request: 1'b0,
                       writeback_valid: 1'b0, writeback_page: '0,
                       writeback_frame: '0, resident_count: occ_q, last: 1'b1};
          state_q <= S_OUT;
          case (req_q.op)
            OP_FETCH, OP_CREATE: begin
              if (hit_q) begin
                if (pins_q[hidx_q] != PIN_MAX) pins_q[hidx_q] <= pins_q[hidx_q] + 1'b1;
                if (evict_q[hidx_q]) begin
                  for (int i = 0; i < NUM_FRAMES; i++) begin
                    if (evict_q[i] && rec_q[i] > rec_q[hidx_q]) rec_q[i] <= rec_q[i] - 1'b1;
                  end
                  evict_q[hidx_q] <= 1'b0;
                  rec_q[hidx_q]   <= '0;
                  ecnt_q          <= ecnt_q - 1'b1;
                end
                res_q.status      <= ST_HIT;
                res_q.frame_index <= hidx_q;
              end else if (occ_q >= lim) begin
                if (!vic_any) begin
                  res_q.status <= ST_FULL;
                end else begin
                  // oldest frame leaves the list; nobody ranks above it
                  wbv_q            <= dirty_q[vic_idx];
                  wbp_q            <= dirty_q[vic_idx] ? page_q[vic_idx] : '0;
                  wbf_q            <= dirty_q[vic_idx] ? vic_idx : '0;
                  valid_q[vic_idx] <= 1'b0;
                  dirty_q[vic_idx] <= 1'b0;
                  pins_q[vic_idx]  <= '0;
                  evict_q[vic_idx] <= 1'b0;
                  rec_q[vic_idx]   <= '0;
                  ecnt_q           <= ecnt_q - 1'b1;
                  occ_q            <= occ_q - 1'b1;
                  state_q          <= S_ALLOC;
                end
              end else begin
                wbv_q   <= 1'b0;
                wbp_q   <= '0;
                wbf_q   <= '0;
                state_q <= S_ALLOC;
              end
            end
            OP_UNPIN: begin
              if (hit_q) begin
                if (req_q.set_dirty) dirty_q[hidx_q] <= 1'b1;
                pins_q[hidx_q] <= unpin_pins;
                if (unpin_pins == '0) begin
                  // move to the most recent position
                  for (int i = 0; i < NUM_FRAMES; i++) begin
                    if (evict_q[i] && FRAME_BITS'(i) != hidx_q) begin
                      rec_q[i] <= rec_q[i] + 1'b1 -
                                  FRAME_BITS'(evict_q[hidx_q] && rec_q[i] > rec_q[hidx_q]);
                    end
                  end
                  evict_q[hidx_q] <= 1'b1;
                  rec_q[hidx_q]   <= '0;
                  ecnt_q          <= ecnt_q + CNT_BITS'(!evict_q[hidx_q]);
                end
                res_q.status      <= ST_HIT;
                res_q.frame_index <= hidx_q;
              end
            end
            OP_FLUSH: begin
              if (hit_q) begin
                res_q.status      <= ST_HIT;
                res_q.frame_index <= hidx_q;
                if (dirty_q[hidx_q]) begin
                  dirty_q[hidx_q]       <= 1'b0;
                  res_q.writeback_valid <= 1'b1;
                  res_q.writeback_page  <= page_q[hidx_q];
                  res_q.writeback_frame <= hidx_q;
                end
              end
            end
            OP_FLUSH_ALL: begin
              res_q.status <= ST_HIT;
              if (dirty_any) begin
                widx_q  <= '0;
                state_q <= S_WALK;
              end
            end
            default: ;
          endcase
        end
        S_ALLOC: begin
          res_q <= '{status: ST_FULL, frame_index: '0, load_request: 1'b0,
                     writeback_valid: 1'b0, writeback_page: '0,
                     writeback_frame: '0, resident_count: occ_q, last: 1'b1};
          if (free_any) begin
            valid_q[free_idx] <= 1'b1;
            pins_q[free_idx]  <= PIN_ONE;
            dirty_q[free_idx] <= (req_q.op == OP_CREATE);
            evict_q[free_idx] <= 1'b0;
            rec_q[free_idx]   <= '0;
            occ_q             <= occ_q + 1'b1;
            res_q <= '{status: ST_NEW, frame_index: free_idx,
                       load_request: (req_q.op == OP_FETCH),
                       writeback_valid: wbv_q, writeback_page: wbp_q,
                       writeback_frame: wbf_q, resident_count: occ_q + 1'b1,
                       last: 1'b1};
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_full_i) state_q <= S_IDLE;
        end
        S_WALK: begin
          if (!cur_dirty) begin
            widx_q <= widx_q + 1'b1;
          end else if (!out_full_i) begin
            dirty_q[widx_q] <= 1'b0;
            if (!above_any) state_q <= S_IDLE;
            else widx_q <= widx_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- sv/pinned_page_frame_lru_pool_core.sv -----
// ----------------------------------------------------------------------------
// pinned_page_frame_lru_pool_core
// Frame table of a page buffer pool with pin counts and LRU replacement.
// ----------------------------------------------------------------------------
// Requests enter on push/full; each names a mode, a page id and a dirty flag.
// Results leave on empty/pop; the oldest result is shown while empty is low.
// A request yields one result, except flush all with dirty frames, which
// yields one per dirty frame in frame order, the final one flagged by last.
// The front decodes the request into a two-entry queue; the back sequencer
// takes one request at a time: pop, tag compare, execute, hand off, with a
// frame-claim step for a miss and a walk over the frames for flush all.
// The back stalls while the two-entry result queue is full, and the request
// queue keeps accepting until it fills.
// The pool limit is written on cfg_valid_i/cfg_ready_o (always ready); the
// user must write it only while idle, which the block does not enforce.
// Reset empties the table, both queues and sets the limit to 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pinned_page_frame_lru_pool_core #(
  parameter int PIN_BITS = ppf_pkg::DEF_PIN_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [ppf_pkg::MODE_BITS-1:0]  mode_i,
  input  wire logic [ppf_pkg::PAGE_BITS-1:0]  page_id_i,
  input  wire logic                           set_dirty_i,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [ppf_pkg::STAT_BITS-1:0]       status_o,
  output logic [ppf_pkg::FRAME_BITS-1:0]      frame_index_o,
  output logic                                load_request_o,
  output logic                                writeback_valid_o,
  output logic [ppf_pkg::PAGE_BITS-1:0]       writeback_page_o,
  output logic [ppf_pkg::FRAME_BITS-1:0]      writeback_frame_o,
  output logic [ppf_pkg::CNT_BITS-1:0]        resident_count_o,
  output logic                                last_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ppf_pkg::CNT_BITS-1:0]   cfg_data_i
);
  import ppf_pkg::*;

  logic [CNT_BITS-1:0] limit_q;
  logic                q_full, q_push, q_empty, q_pop;
  req_t                q_in, q_out;
  logic                o_full, o_push;
  res_t                o_in, o_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  ppf_front u_front (
    .push        (push),
    .full        (full),
    .mode_i      (mode_i),
    .page_id_i   (page_id_i),
    .set_dirty_i (set_dirty_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_req_o     (q_in)
  );

  ppf_fifo #(.WIDTH($bits(req_t)), .DEPTH(QUEUE_DEPTH)) u_req_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  ppf_back #(.PIN_BITS(PIN_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_i    (limit_q),
    .q_empty_i  (q_empty),
    .q_req_i    (q_out),
    .q_pop_o    (q_pop),
    .out_full_i (o_full),
    .out_push_o (o_push),
    .out_res_o  (o_in)
  );

  ppf_fifo #(.WIDTH($bits(res_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (o_push),
    .data_i  (o_in),
    .full_o  (o_full),
    .pop_i   (pop),
    .data_o  (o_out),
    .empty_o (empty)
  );

  assign status_o          = o_out.status;
  assign frame_index_o     = o_out.frame_index;
  assign load_request_o    = o_out.load_request;
  assign writeback_valid_o = o_out.writeback_valid;
  assign writeback_page_o  = o_out.writeback_page;
  assign writeback_frame_o = o_out.writeback_frame;
  assign resident_count_o  = o_out.resident_count;
  assign last_o            = o_out.last;
endmodule
`default_nettype wire

// ----- sv/ppf_chk.sv -----
// ----------------------------------------------------------------------------
// ppf_chk
// Port-level checks of the frame pool, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ppf_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          empty,
  input wire logic                          pop,
  input wire logic [ppf_pkg::STAT_BITS-1:0] status_o,
  input wire logic                          load_request_o,
  input wire logic                          writeback_valid_o,
  input wire logic [ppf_pkg::PAGE_BITS-1:0] writeback_page_o,
  input wire logic [ppf_pkg::CNT_BITS-1:0]  resident_count_o
);
  import ppf_pkg::*;

  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(status_o) && $stable(writeback_page_o))
    else $error("result changed while waiting");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && load_request_o |-> status_o == ST_NEW)
    else $error("load request without a new frame");

  a_wb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !writeback_valid_o |-> writeback_page_o == '0)
    else $error("stray writeback page");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> resident_count_o <= CNT_BITS'(NUM_FRAMES))
    else $error("resident count above pool size");
endmodule

bind pinned_page_frame_lru_pool_core ppf_chk u_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .empty             (empty),
  .pop               (pop),
  .status_o          (status_o),
  .load_request_o    (load_request_o),
  .writeback_valid_o (writeback_valid_o),
  .writeback_page_o  (writeback_page_o),
  .resident_count_o  (resident_count_o)
);
`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pinned page frame pool with LRU replacement.
// ----------------------------------------------------------------------------
// A directed table covers reset behavior, every mode, eviction with and
// without writeback, pin saturation and limit extremes.
// Random phases follow under several idle/stall mixes and pool limits. A
// behavioral frame table predicts each result, which is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import ppf_pkg::*;

  localparam int PIN_MAX = 255;
  localparam int WDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [MODE_BITS-1:0] mode_i = '0;
  logic [PAGE_BITS-1:0] page_id_i = '0;
  logic set_dirty_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [STAT_BITS-1:0] status_o;
  logic [FRAME_BITS-1:0] frame_index_o;
  logic load_request_o;
  logic writeback_valid_o;
  logic [PAGE_BITS-1:0] writeback_page_o;
  logic [FRAME_BITS-1:0] writeback_frame_o;
  logic [CNT_BITS-1:0] resident_count_o;
  logic last_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CNT_BITS-1:0] cfg_data_i = '0;

  pinned_page_frame_lru_pool_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .mode_i(mode_i), .page_id_i(page_id_i), .set_dirty_i(set_dirty_i),
    .empty(empty), .pop(pop), .status_o(status_o), .frame_index_o(frame_index_o),
    .load_request_o(load_request_o), .writeback_valid_o(writeback_valid_o),
    .writeback_page_o(writeback_page_o), .writeback_frame_o(writeback_frame_o),
    .resident_count_o(resident_count_o), .last_o(last_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // frame table copy
  logic                 fr_valid [NUM_FRAMES];
  logic [PAGE_BITS-1:0] fr_page  [NUM_FRAMES];
  int unsigned          fr_pins  [NUM_FRAMES];
  logic                 fr_dirty [NUM_FRAMES];
  logic                 fr_lru   [NUM_FRAMES];
  int unsigned          fr_age   [NUM_FRAMES];
  int unsigned          fr_occ;
  int unsigned          pool_limit;

  res_t pending_results[$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_off = 0;

  task automatic report(input string what, input int got, input int want);
    $display("[%0t] %s: got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void lru_remove(input int f);
    if (!fr_lru[f]) return;
    for (int i = 0; i < NUM_FRAMES; i++)
      if (fr_lru[i] && fr_age[i] > fr_age[f]) fr_age[i]--;
    fr_lru[f] = 1'b0;
    fr_age[f] = 0;
  endfunction

  function automatic void lru_touch(input int f);
    lru_remove(f);
    for (int i = 0; i < NUM_FRAMES; i++)
      if (fr_lru[i]) fr_age[i]++;
    fr_lru[f] = 1'b1;
    fr_age[f] = 0;
  endfunction

  function automatic int lookup(input logic [PAGE_BITS-1:0] pg);
    for (int i = 0; i < NUM_FRAMES; i++)
      if (fr_valid[i] && fr_page[i] == pg) return i;
    return -1;
  endfunction

  function automatic res_t mk(input logic [STAT_BITS-1:0] st, input int fi,
                              input int ld, input int wv,
                              input logic [PAGE_BITS-1:0] wp, input int wf,
                              input int lst);
    res_t r;
    r.status = st;
    r.frame_index = FRAME_BITS'(fi);
    r.load_request = 1'(ld);
    r.writeback_valid = 1'(wv);
    r.writeback_page = wp;
    r.writeback_frame = FRAME_BITS'(wf);
    r.resident_count = CNT_BITS'(fr_occ);
    r.last = 1'(lst);
    return r;
  endfunction

  function automatic void predict_request(input logic [MODE_BITS-1:0] md,
                                          input logic [PAGE_BITS-1:0] pg,
                                          input logic sd);
    int f, v, n, lim;
    logic wv;
    logic [PAGE_BITS-1:0] wp;
    int wf;
    lim = (pool_limit == 0) ? 1 : (pool_limit > NUM_FRAMES ? NUM_FRAMES : pool_limit);
    wv = 1'b0; wp = '0; wf = 0;
    f = lookup(pg);
    case (md)
      MODE_FETCH, MODE_CREATE: begin
        if (f >= 0) begin
          if (fr_pins[f] < PIN_MAX) fr_pins[f]++;
          lru_remove(f);
          pending_results.push_back(mk(ST_HIT, f, 0, 0, '0, 0, 1));
          return;
        end
        if (fr_occ >= lim) begin
          v = -1;
          for (int i = 0; i < NUM_FRAMES; i++)
            if (fr_valid[i] && fr_lru[i] && (v < 0 || fr_age[i] > fr_age[v])) v = i;
          if (v < 0) begin
            pending_results.push_back(mk(ST_FULL, 0, 0, 0, '0, 0, 1));
            return;
          end
          if (fr_dirty[v]) begin
            wv = 1'b1; wp = fr_page[v]; wf = v;
          end
          lru_remove(v);
          fr_valid[v] = 1'b0;
          fr_dirty[v] = 1'b0;
          fr_pins[v] = 0;
          fr_occ--;
        end
        f = -1;
        for (int i = 0; i < NUM_FRAMES; i++)
          if (f < 0 && !fr_valid[i]) f = i;
        if (f < 0) begin
          pending_results.push_back(mk(ST_FULL, 0, 0, 0, '0, 0, 1));
          return;
        end
        fr_valid[f] = 1'b1;
        fr_page[f] = pg;
        fr_pins[f] = 1;
        fr_dirty[f] = (md == MODE_CREATE);
        fr_lru[f] = 1'b0;
        fr_age[f] = 0;
        fr_occ++;
        pending_results.push_back(mk(ST_NEW, f, md == MODE_FETCH, wv, wp, wf, 1));
      end
      MODE_UNPIN: begin
        if (f < 0) begin
          pending_results.push_back(mk(ST_ABSENT, 0, 0, 0, '0, 0, 1));
          return;
        end
        if (sd) fr_dirty[f] = 1'b1;
        if (fr_pins[f] > 0) fr_pins[f]--;
        if (fr_pins[f] == 0) lru_touch(f);
        pending_results.push_back(mk(ST_HIT, f, 0, 0, '0, 0, 1));
      end
      MODE_FLUSH: begin
        if (f < 0) begin
          pending_results.push_back(mk(ST_ABSENT, 0, 0, 0, '0, 0, 1));
        end else if (fr_dirty[f]) begin
          fr_dirty[f] = 1'b0;
          pending_results.push_back(mk(ST_HIT, f, 0, 1, fr_page[f], f, 1));
        end else begin
          pending_results.push_back(mk(ST_HIT, f, 0, 0, '0, 0, 1));
        end
      end
      MODE_FLUSH_ALL: begin
        n = 0;
        for (int i = 0; i < NUM_FRAMES; i++)
          if (fr_valid[i] && fr_dirty[i]) begin
            fr_dirty[i] = 1'b0;
            pending_results.push_back(mk(ST_HIT, 0, 0, 1, fr_page[i], i, 0));
            n++;
          end
        if (n == 0) pending_results.push_back(mk(ST_HIT, 0, 0, 0, '0, 0, 1));
        else pending_results[$].last = 1'b1;
      end
      default: pending_results.push_back(mk(ST_ABSENT, 0, 0, 0, '0, 0, 1));
    endcase
  endfunction

  // result side: random stall plus long hold-off, checked at the edge
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          report("unexpected result", status_o, 0);
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status) report("status", status_o, want.status);
          if (frame_index_o !== want.frame_index)
            report("frame_index", frame_index_o, want.frame_index);
          if (load_request_o !== want.load_request)
            report("load_request", load_request_o, want.load_request);
          if (writeback_valid_o !== want.writeback_valid)
            report("writeback_valid", writeback_valid_o, want.writeback_valid);
          if (writeback_page_o !== want.writeback_page)
            report("writeback_page", writeback_page_o, want.writeback_page);
          if (writeback_frame_o !== want.writeback_frame)
            report("writeback_frame", writeback_frame_o, want.writeback_frame);
          if (resident_count_o !== want.resident_count)
            report("resident_count", resident_count_o, want.resident_count);
          if (last_o !== want.last) report("last", last_o, want.last);
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: cycles with no accepted request or result
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("pinned_page_frame_lru_pool_core: mismatch");
      $finish;
    end
  end

  // push stays high after an accepted request until the next call decides
  task automatic send(input logic [MODE_BITS-1:0] md, input logic [PAGE_BITS-1:0] pg,
                      input logic sd);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    mode_i <= md;
    page_id_i <= pg;
    set_dirty_i <= sd;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_request(md, pg, sd);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_limit(input int unsigned val);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= CNT_BITS'(val);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    pool_limit = val;
  endtask

  // random request over a small page set so hits, evictions and pins mix
  task automatic random_request(input int pages);
    int r;
    logic [PAGE_BITS-1:0] pg;
    r = $urandom_range(99);
    pg = ($urandom_range(19) == 0) ? PAGE_BITS'($urandom) :
         PAGE_BITS'(32'hA500_0000 + $urandom_range(pages - 1));
    if (r < 30) send(MODE_FETCH, pg, 1'($urandom_range(1)));
    else if (r < 45) send(MODE_CREATE, pg, 1'($urandom_range(1)));
    else if (r < 82) send(MODE_UNPIN, pg, 1'($urandom_range(1)));
    else if (r < 92) send(MODE_FLUSH, pg, 1'($urandom_range(1)));
    else if (r < 96) send(MODE_FLUSH_ALL, PAGE_BITS'($urandom), 1'($urandom_range(1)));
    else send(MODE_BITS'($urandom_range(7, 5)), pg, 1'($urandom_range(1)));
  endtask

  typedef struct {
    logic [MODE_BITS-1:0] md;
    logic [PAGE_BITS-1:0] pg;
    logic                 sd;
    logic                 typed;
    logic [STAT_BITS-1:0] st;
  } stim_row_t;

  stim_row_t directed_rows[$];

  initial begin
    int got;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      fr_valid[i] = 0; fr_page[i] = '0; fr_pins[i] = 0;
      fr_dirty[i] = 0; fr_lru[i] = 0; fr_age[i] = 0;
    end
    fr_occ = 0;
    pool_limit = NUM_FRAMES;

    // typed status only where it is obvious; the predictor checks all fields
    directed_rows = '{
      '{MODE_UNPIN,     32'h0000_0000, 1'b0, 1'b1, ST_ABSENT},
      '{MODE_FLUSH,     32'hFFFF_FFFF, 1'b0, 1'b1, ST_ABSENT},
      '{MODE_FLUSH_ALL, 32'h1234_5678, 1'b0, 1'b1, ST_HIT},
      '{3'd7,           32'h0000_0001, 1'b1, 1'b1, ST_ABSENT},
      '{MODE_FETCH,     32'h0000_0000, 1'b0, 1'b1, ST_NEW},
      '{MODE_CREATE,    32'hFFFF_FFFF, 1'b0, 1'b1, ST_NEW},
      '{MODE_FETCH,     32'hFFFF_FFFF, 1'b0, 1'b1, ST_HIT},
      '{MODE_UNPIN,     32'hFFFF_FFFF, 1'b0, 1'b0, ST_HIT},
      '{MODE_UNPIN,     32'hFFFF_FFFF, 1'b0, 1'b0, ST_HIT},
      '{MODE_UNPIN,     32'hFFFF_FFFF, 1'b0, 1'b0, ST_HIT},
      '{MODE_UNPIN,     32'h0000_0000, 1'b1, 1'b0, ST_HIT},
      '{MODE_FLUSH,     32'h0000_0000, 1'b0, 1'b0, ST_HIT},
      '{MODE_FLUSH,     32'h0000_0000, 1'b0, 1'b0, ST_HIT},
      '{MODE_UNPIN,     32'h0000_0000, 1'b1, 1'b0, ST_HIT},
      '{MODE_FLUSH_ALL, 32'h0,         1'b0, 1'b0, ST_HIT},
      '{3'd5,           32'h5555_AAAA, 1'b0, 1'b1, ST_ABSENT},
      '{3'd6,           32'hAAAA_5555, 1'b1, 1'b1, ST_ABSENT}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      got = pending_results.size();
      send(directed_rows[k].md, directed_rows[k].pg, directed_rows[k].sd);
      if (directed_rows[k].typed && pending_results.size() > got &&
          pending_results[got].status != directed_rows[k].st)
        report("directed row status", pending_results[got].status, directed_rows[k].st);
    end

    // limit 1: clean evictions, then a dirty eviction with writeback
    set_limit(1);
    send(MODE_CREATE, 32'hC0DE_0001, 1'b0);
    send(MODE_UNPIN, 32'hC0DE_0001, 1'b1);
    send(MODE_FETCH, 32'hC0DE_0002, 1'b0);
    send(MODE_FETCH, 32'hC0DE_0003, 1'b0);
    // limit 0 acts as 1; pin saturation on one page
    set_limit(0);
    for (int i = 0; i < 260; i++) send(MODE_FETCH, 32'hC0DE_0002, 1'b0);
    send(MODE_UNPIN, 32'hC0DE_0002, 1'b0);
    set_limit(31);

    // random phases across idle mixes and limits, including a fill-up stall
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      case (ph)
        1: set_limit(NUM_FRAMES);
        2: set_limit(4);
        3: set_limit(17);
        4: set_limit(2);
        5: set_limit(8);
        6: set_limit(1);
        7: set_limit(NUM_FRAMES);
        default: ;
      endcase
      if (ph == 2) hold_off = 300;
      for (int n = 0; n < 12; n++) random_request(ph < 4 ? 12 : 24);
      if (ph == 5) wait_drained();
      for (int n = 0; n < 12; n++) random_request(ph < 4 ? 12 : 24);
    end

    wait_drained();
    if (mismatches == 0) $display("pinned_page_frame_lru_pool_core: match");
    else $display("pinned_page_frame_lru_pool_core: mismatch");
    $finish;
  end
endmodule

// ----- files.f -----
sv/ppf_pkg.sv
sv/ppf_fifo.sv
sv/ppf_front.sv
sv/ppf_back.sv
sv/pinned_page_frame_lru_pool_core.sv
sv/ppf_chk.sv
test/testbench.sv
